// ----- src/lbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the LED blink controller
// Command codes, per-LED entry layout and sizing constants.
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int NUM_LEDS = 2;
	localparam int IDX_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	// level vector is at least as wide as the led_levels port
	localparam int LVL_W    = (NUM_LEDS > 2) ? NUM_LEDS : 2;

	localparam logic [1:0] CMD_ON    = 2'd0;
	localparam logic [1:0] CMD_OFF   = 2'd1;
	localparam logic [1:0] CMD_BLINK = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	localparam logic [7:0]  BLINK_FOREVER = 8'hFF;
	localparam logic [15:0] TICK_STEP_RST = 16'd1;

	localparam logic [1:0] ADDR_TICK_STEP = 2'd0;

	localparam logic [0:0] STATUS_OK      = 1'b0;
	localparam logic [0:0] STATUS_BAD_IDX = 1'b1;

	// one memory word per LED
	typedef struct packed {
		logic [7:0]  blinks;
		logic [15:0] timer;
		logic [15:0] reload;
	} ent_t;

endpackage

// ----- src/led_blink_controller.sv -----
// ----------------------------------------------------------------------------
// led_blink_controller
// Command-driven LED blinker: on, off, start blink and tick, with the
// per-LED blink state held in a small synchronous memory.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  -------   ---------  ---------          -------
//  in        request    in_valid/in_ready  cmd, led_index, blink_count,
//                                          blink_period
//  out       result     out_valid/ready    led_levels, status
//  apb       config     psel/penable/...   tick_step at byte address 0
//
//  An on, off or start-blink request makes one step in the read-modify-write
//  stage after acceptance; a tick makes one step per LED, since
//  the single memory read port serves one entry per cycle. A new request is
//  taken the cycle after the previous one leaves that stage.
//  Reset clears the memory valid bits, the levels and tick_step (to 1); an
//  entry not written since reset reads as zero, so no clearing pass runs.
//  A full output register that is not taken holds the last step of a request.
// ----------------------------------------------------------------------------
module led_blink_controller (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [1:0]  led_index,
	input  logic [7:0]  blink_count,
	input  logic [15:0] blink_period,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  led_levels,
	output logic [0:0]  status
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_MW   = 1'b1;

	localparam logic [lbc_pkg::IDX_W-1:0] LAST_IDX = lbc_pkg::IDX_W'(lbc_pkg::NUM_LEDS - 1);

	// ---------------- configuration register ----------------
	logic [15:0] tick_step_q;

	assign pready = 1'b1;
	assign prdata = (paddr == lbc_pkg::ADDR_TICK_STEP) ? {16'd0, tick_step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= lbc_pkg::TICK_STEP_RST;
		end else if (psel && penable && pwrite && pready
		             && paddr == lbc_pkg::ADDR_TICK_STEP) begin
			tick_step_q <= pwdata[15:0];
		end
	end

	// ---------------- control state ----------------
	logic                      state_q;
	logic [lbc_pkg::IDX_W-1:0] cur_q;
	logic [lbc_pkg::LVL_W-1:0] lvl_q;
	logic [lbc_pkg::NUM_LEDS-1:0] vld_q;   // entry written since reset
	logic                      out_valid_q;
	logic [1:0]                led_levels_q;
	logic [0:0]                status_q;

	// captured request
	logic [1:0]  cmd_q;
	logic [1:0]  idx_q;
	logic [7:0]  cnt_q;
	logic [15:0] per_q;

	// ---------------- entry memory ----------------
	lbc_pkg::ent_t mem_q [lbc_pkg::NUM_LEDS];
	lbc_pkg::ent_t rd_data_s1;
	logic          rd_vld_s1;

	logic                      rd_en;
	logic [lbc_pkg::IDX_W-1:0] rd_addr;
	logic                      wr_en;
	lbc_pkg::ent_t             wr_data;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
			rd_vld_s1  <= vld_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[cur_q] <= wr_data;
		end
	end

	// ---------------- request sequencing ----------------
	logic accept;
	logic bad_idx;
	logic last;
	logic stall;
	logic step;
	logic in_range;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = ({30'd0, led_index} < lbc_pkg::NUM_LEDS);

	assign bad_idx = (cmd_q != lbc_pkg::CMD_TICK) && !({30'd0, idx_q} < lbc_pkg::NUM_LEDS);
	assign last    = (cmd_q != lbc_pkg::CMD_TICK) || (cur_q == LAST_IDX);
	// final step waits for a free output register
	assign stall   = last && out_valid_q && !out_ready;
	assign step    = (state_q == ST_MW) && !stall;

	// Read is issued with acceptance, then for a tick one entry ahead of the
	// write. A read never targets the entry being written: the next request
	// is accepted only after the last write has landed.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (accept) begin
			if (cmd == lbc_pkg::CMD_TICK) begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end else begin
				rd_en   = in_range;
				rd_addr = led_index[lbc_pkg::IDX_W-1:0];
			end
		end else if (step && !last) begin
			rd_en   = 1'b1;
			rd_addr = cur_q + 1'b1;
		end
	end

	// ---------------- modify ----------------
	lbc_pkg::ent_t cur_ent;
	logic          cur_lvl;
	logic          new_lvl;

	assign cur_ent = rd_vld_s1 ? rd_data_s1 : '0;
	assign cur_lvl = lvl_q[cur_q];

	always_comb begin
		wr_data = cur_ent;
		new_lvl = cur_lvl;
		case (cmd_q)
			lbc_pkg::CMD_ON: begin
				new_lvl        = 1'b1;
				wr_data.blinks = 8'd0;
			end
			lbc_pkg::CMD_OFF: begin
				new_lvl        = 1'b0;
				wr_data.blinks = 8'd0;
			end
			lbc_pkg::CMD_BLINK: begin
				wr_data.blinks = cnt_q;
				wr_data.timer  = per_q;
				wr_data.reload = per_q;
			end
			default: begin
				// tick
				if (cur_ent.blinks != 8'd0) begin
					if (cur_ent.timer > tick_step_q) begin
						wr_data.timer = cur_ent.timer - tick_step_q;
					end else begin
						wr_data.timer = cur_ent.reload;
						new_lvl       = !cur_lvl;
						if (cur_lvl && cur_ent.blinks != lbc_pkg::BLINK_FOREVER) begin
							wr_data.blinks = cur_ent.blinks - 8'd1;
						end
					end
				end
			end
		endcase
	end

	assign wr_en = step && !bad_idx;

	logic [lbc_pkg::LVL_W-1:0] lvl_nxt;

	always_comb begin
		lvl_nxt = lvl_q;
		if (wr_en) begin
			lvl_nxt[cur_q] = new_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			lvl_q       <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				state_q <= ST_MW;
				cur_q   <= (cmd == lbc_pkg::CMD_TICK) ? '0 : led_index[lbc_pkg::IDX_W-1:0];
			end else if (step) begin
				if (last) begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end else begin
					cur_q <= cur_q + 1'b1;
				end
			end
			if (wr_en) begin
				vld_q[cur_q] <= 1'b1;
			end
			lvl_q <= lvl_nxt;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			idx_q <= led_index;
			cnt_q <= blink_count;
			per_q <= blink_period;
		end
		if (step && last) begin
			led_levels_q <= lvl_nxt[1:0];
			status_q     <= bad_idx ? lbc_pkg::STATUS_BAD_IDX : lbc_pkg::STATUS_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign led_levels = led_levels_q;
	assign status     = status_q;

	// ---------------- assertions ----------------
	a_wr_only_in_mw: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_MW)
		else $error("memory write outside modify stage");

	a_accept_to_mw: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MW)
		else $error("accepted request did not enter modify stage");

	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> rd_addr != cur_q)
		else $error("read and write of the same entry in one cycle");

	a_result_after_mw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_MW)
		else $error("result raised without a finished request");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the LED blink controller
// Drives on, off, start-blink and tick requests with random gaps and stalls.
// A scoreboard keeps its own copy of the LED levels, blink counters and
// timers, predicts the one result of each request and compares every result.
// tick_step is changed through the APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int NUM_PHASES      = 5;
	// a tick makes one step per LED in the update stage; allow some margin
	localparam int SETTLE_CYCLES   = lbc_pkg::NUM_LEDS + 6;

	typedef struct {
		logic [1:0] levels;
		logic [0:0] status;
	} led_res_t;

	// ------------------------------------------------------------------
	// Scoreboard: LED state copy, expected results, mismatch count
	// ------------------------------------------------------------------
	class led_scoreboard;
		logic [15:0] tick_step;
		logic        level [lbc_pkg::NUM_LEDS];
		logic [7:0]  blinks_left [lbc_pkg::NUM_LEDS];
		logic [15:0] time_left [lbc_pkg::NUM_LEDS];
		logic [15:0] reload_period [lbc_pkg::NUM_LEDS];
		led_res_t    pending_results [$];
		int          mismatches;

		function new();
			for (int i = 0; i < lbc_pkg::NUM_LEDS; i++) begin
				level[i]         = 1'b0;
				blinks_left[i]   = 8'd0;
				time_left[i]     = 16'd0;
				reload_period[i] = 16'd0;
			end
			tick_step  = lbc_pkg::TICK_STEP_RST;
			mismatches = 0;
		endfunction

		task report_mismatch(input string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			mismatches++;
		endtask

		// Update the LED state for one accepted request and queue its result.
		function void note_request(input logic [1:0] r_cmd, input logic [1:0] r_idx,
				input logic [7:0] r_count, input logic [15:0] r_period);
			led_res_t exp;
			exp.status = lbc_pkg::STATUS_OK;
			if (r_cmd == lbc_pkg::CMD_TICK) begin
				for (int i = 0; i < lbc_pkg::NUM_LEDS; i++) begin
					if (blinks_left[i] != 8'd0) begin
						if (time_left[i] > tick_step) begin
							time_left[i] = time_left[i] - tick_step;
						end else begin
							// timer ran out: reload and toggle
							time_left[i] = reload_period[i];
							if (level[i]) begin
								level[i] = 1'b0;
								if (blinks_left[i] != lbc_pkg::BLINK_FOREVER)
									blinks_left[i] = blinks_left[i] - 8'd1;
							end else begin
								level[i] = 1'b1;
							end
						end
					end
				end
			end else if (int'(r_idx) >= lbc_pkg::NUM_LEDS) begin
				exp.status = lbc_pkg::STATUS_BAD_IDX;
			end else if (r_cmd == lbc_pkg::CMD_ON) begin
				level[r_idx]       = 1'b1;
				blinks_left[r_idx] = 8'd0;
			end else if (r_cmd == lbc_pkg::CMD_OFF) begin
				level[r_idx]       = 1'b0;
				blinks_left[r_idx] = 8'd0;
			end else begin
				time_left[r_idx]     = r_period;
				reload_period[r_idx] = r_period;
				blinks_left[r_idx]   = r_count;
			end
			exp.levels = '0;
			for (int i = 0; i < lbc_pkg::NUM_LEDS && i < 2; i++)
				exp.levels[i] = level[i];
			pending_results.push_back(exp);
		endfunction

		task check_result(input logic [1:0] got_levels, input logic [0:0] got_status);
			led_res_t exp;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				exp = pending_results.pop_front();
				if (got_levels !== exp.levels)
					report_mismatch($sformatf("led_levels %b, expected %b",
						got_levels, exp.levels));
				if (got_status !== exp.status)
					report_mismatch($sformatf("status %b, expected %b",
						got_status, exp.status));
			end
		endtask
	endclass

	// ------------------------------------------------------------------
	// DUT signals and instance
	// ------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [1:0]  led_index;
	logic [7:0]  blink_count;
	logic [15:0] blink_period;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  led_levels;
	logic [0:0]  status;

	led_blink_controller i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.led_index    (led_index),
		.blink_count  (blink_count),
		.blink_period (blink_period),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_levels   (led_levels),
		.status       (status)
	);

	led_scoreboard sb = new();

	// idle percentages of the current phase (per cycle)
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	// ------------------------------------------------------------------
	// Clock, watchdog, result side
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: ready decided per cycle at the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(led_levels, status);
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Mostly short periods so timers actually run out, plus the extremes
	// and full-range values to reach every bit.
	function automatic logic [15:0] rand_period();
		case ($urandom_range(9))
			0, 1, 2, 3: return 16'($urandom_range(4));
			4, 5:       return 16'($urandom_range(40));
			6:          return 16'hFFFF;
			7:          return 16'h0000;
			default:    return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_count();
		case ($urandom_range(9))
			0, 1, 2, 3: return 8'($urandom_range(1, 4));
			4:          return 8'd0;
			5:          return lbc_pkg::BLINK_FOREVER;
			default:    return 8'($urandom_range(255));
		endcase
	endfunction

	// One request: optional idle gap, then hold valid until accepted.
	task automatic send_req(input logic [1:0] r_cmd, input logic [1:0] r_idx,
			input logic [7:0] r_count, input logic [15:0] r_period);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		cmd          <= r_cmd;
		led_index    <= r_idx;
		blink_count  <= r_count;
		blink_period <= r_period;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(r_cmd, r_idx, r_count, r_period);
	endtask

	// Stop sending and wait for every outstanding result, then let the
	// update stage settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of tick_step, then read it back.
	task automatic set_tick_step(input logic [15:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lbc_pkg::ADDR_TICK_STEP;
		pwdata  <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.tick_step = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== value)
			sb.report_mismatch($sformatf("tick_step reads %h, expected %h",
				prdata[15:0], value));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	logic [15:0] phase_step [NUM_PHASES];
	int          phase_send [NUM_PHASES] = '{0, 80, 0, 38, 0};
	int          phase_recv [NUM_PHASES] = '{0, 0, 80, 38, 0};

	initial begin
		int          sent;
		int          n_ticks;
		bit          paused;
		logic [1:0]  r_cmd;
		logic [1:0]  r_idx;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		cmd          = lbc_pkg::CMD_ON;
		led_index    = '0;
		blink_count  = '0;
		blink_period = '0;

		// tick_step extremes and zero, then mid values
		phase_step = '{16'hFFFF, 16'd0, 16'd3, 16'd1, 16'($urandom_range(2, 400))};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed part, tick_step at its reset value of 1 ---
		// tick with nothing blinking
		send_req(lbc_pkg::CMD_TICK,  2'd0, 8'd0,   16'd0);
		send_req(lbc_pkg::CMD_ON,    2'd0, 8'hFF,  16'hFFFF);
		send_req(lbc_pkg::CMD_ON,    2'd1, 8'd0,   16'd0);
		send_req(lbc_pkg::CMD_ON,    2'd2, 8'd1,   16'd1);     // bad index
		send_req(lbc_pkg::CMD_OFF,   2'd3, 8'hFF,  16'hFFFF);  // bad index
		send_req(lbc_pkg::CMD_BLINK, 2'd3, 8'd5,   16'd5);     // bad index
		send_req(lbc_pkg::CMD_OFF,   2'd1, 8'd0,   16'd0);
		// zero period: toggles on every tick, count of two runs out
		send_req(lbc_pkg::CMD_BLINK, 2'd0, 8'd2,   16'd0);
		repeat (5) send_req(lbc_pkg::CMD_TICK, 2'd3, 8'hFF, 16'hFFFF);
		// blink forever on LED 1
		send_req(lbc_pkg::CMD_BLINK, 2'd1, lbc_pkg::BLINK_FOREVER, 16'd1);
		repeat (3) send_req(lbc_pkg::CMD_TICK, 2'd1, 8'd0, 16'd0);
		// zero count stops blinking and keeps the level
		send_req(lbc_pkg::CMD_BLINK, 2'd1, 8'd0,   16'd5);
		send_req(lbc_pkg::CMD_BLINK, 2'd0, 8'd3,   16'hFFFF);  // longest period
		send_req(lbc_pkg::CMD_TICK,  2'd0, 8'd0,   16'd0);
		send_req(lbc_pkg::CMD_ON,    2'd0, 8'd0,   16'd0);     // on stops blinking
		send_req(lbc_pkg::CMD_BLINK, 2'd0, lbc_pkg::BLINK_FOREVER, 16'd2);
		send_req(lbc_pkg::CMD_TICK,  2'd2, 8'd0,   16'd0);
		send_req(lbc_pkg::CMD_TICK,  2'd0, 8'd0,   16'd0);
		send_req(lbc_pkg::CMD_OFF,   2'd0, 8'd0,   16'd0);

		// --- random phases, one tick_step and idle mix each ---
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results();
			set_tick_step(phase_step[ph]);
			send_idle_pct  = phase_send[ph];
			recv_stall_pct = phase_recv[ph];
			sent   = 0;
			paused = 1'b0;
			while (sent < ITEMS_PER_PHASE) begin
				// halfway through, hold off until everything is back
				if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
					drain_results();
					paused = 1'b1;
				end
				if ($urandom_range(3) == 0) begin
					// well-formed burst: start blink on a real LED, then ticks
					n_ticks = $urandom_range(2, 12);
					send_req(lbc_pkg::CMD_BLINK,
						2'($urandom_range(lbc_pkg::NUM_LEDS - 1)),
						rand_count(), rand_period());
					repeat (n_ticks)
						send_req(lbc_pkg::CMD_TICK, 2'($urandom_range(3)),
							8'($urandom), 16'($urandom));
					sent += 1 + n_ticks;
				end else begin
					r_cmd = ($urandom_range(9) < 4) ? lbc_pkg::CMD_TICK
						: 2'($urandom_range(3));
					r_idx = ($urandom_range(4) == 0) ? 2'($urandom_range(3))
						: 2'($urandom_range(lbc_pkg::NUM_LEDS - 1));
					send_req(r_cmd, r_idx, rand_count(), rand_period());
					sent++;
				end
			end
		end

		drain_results();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
